/* hw/rtl/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// Types and constants shared by the per-session traffic counter block.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int SESSIONS = 1024;
  localparam int ADDR_W   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  typedef enum logic [1:0] {
    REQ_RX   = 2'd0,
    REQ_TX   = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_type_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  session_id;
    logic [15:0] seg_length;
    logic        is_syn;
    logic        is_syn_ack;
    logic        is_retransmit;
  } psc_in_t;

  typedef struct packed {
    logic [63:0] tx_byte_total;
    logic [31:0] tx_packet_total;
    logic [31:0] tx_retransmit_total;
    logic [63:0] rx_byte_total;
    logic [31:0] rx_packet_total;
  } psc_out_t;

  typedef struct packed {
    logic [63:0] bytes;
    logic [31:0] pkts;
  } rx_rec_t;

  typedef struct packed {
    logic [63:0] bytes;
    logic [31:0] pkts;
    logic [31:0] retx;
  } tx_rec_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic              capture;
    logic              clear;
    logic [ADDR_W-1:0] clr_idx;
    logic              update;
    logic              load_out;
  } psc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;
    logic out_free;
  } psc_status_t;

endpackage

/* hw/rtl/psc_ctrl.sv */
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer: clearing pass after reset, then capture / execute per request.
// ----------------------------------------------------------------------------
module psc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  psc_pkg::psc_status_t  status,
  output psc_pkg::psc_cmd_t     cmd
);
  import psc_pkg::*;

  ctl_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_idx_r, clr_idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + ADDR_W'(1);
        if (clr_idx_r == ADDR_W'(SESSIONS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // a read waits here until the output register can take it
        if (!status.is_read || status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != ST_IDLE);
    cmd.capture  = (state_r == ST_IDLE) && in_valid;
    cmd.clear    = (state_r == ST_CLEAR);
    cmd.clr_idx  = clr_idx_r;
    cmd.update   = (state_r == ST_EXEC) && !status.is_read;
    cmd.load_out = (state_r == ST_EXEC) && status.is_read && status.out_free;
  end

endmodule

/* hw/rtl/psc_datapath.sv */
// ----------------------------------------------------------------------------
// psc_datapath
// Counter memories, request register, update arithmetic and output register.
// ----------------------------------------------------------------------------
module psc_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psc_pkg::psc_in_t      in_data,
  input  psc_pkg::psc_cmd_t     cmd,
  output psc_pkg::psc_status_t  status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output psc_pkg::psc_out_t     out_data
);
  import psc_pkg::*;

  rx_rec_t rx_mem [SESSIONS];
  tx_rec_t tx_mem [SESSIONS];

  psc_in_t  req_r;
  rx_rec_t  rx_rd_r;
  tx_rec_t  tx_rd_r;
  psc_out_t out_data_r;
  logic     out_valid_r;

  logic              sid_ok;
  logic              zero_cnt;
  logic              rx_we, tx_we;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  rx_rec_t           rx_wr_data;
  tx_rec_t           tx_wr_data;

  assign rd_addr  = ADDR_W'(in_data.session_id);
  assign sid_ok   = (32'(req_r.session_id) < 32'(SESSIONS));
  assign zero_cnt = req_r.is_syn || req_r.is_syn_ack;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
  end

  always_comb begin
    rx_we      = 1'b0;
    tx_we      = 1'b0;
    wr_addr    = ADDR_W'(req_r.session_id);
    rx_wr_data = '0;
    tx_wr_data = '0;
    if (cmd.clear) begin
      rx_we   = 1'b1;
      tx_we   = 1'b1;
      wr_addr = cmd.clr_idx;
    end else if (cmd.update && sid_ok) begin
      unique case (req_r.req_type)
        REQ_RX: begin
          rx_we = 1'b1;
          if (!zero_cnt) begin
            rx_wr_data.bytes = rx_rd_r.bytes + 64'(req_r.seg_length);
            rx_wr_data.pkts  = rx_rd_r.pkts + 32'd1;
          end
        end
        REQ_TX: begin
          tx_we = 1'b1;
          if (!zero_cnt) begin
            tx_wr_data.bytes = tx_rd_r.bytes + 64'(req_r.seg_length);
            tx_wr_data.pkts  = tx_rd_r.pkts + 32'd1;
            tx_wr_data.retx  = tx_rd_r.retx + 32'(req_r.is_retransmit);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[wr_addr] <= rx_wr_data;
    end
    if (cmd.capture) begin
      rx_rd_r <= rx_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[wr_addr] <= tx_wr_data;
    end
    if (cmd.capture) begin
      tx_rd_r <= tx_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (sid_ok) begin
        out_data_r.tx_byte_total       <= tx_rd_r.bytes;
        out_data_r.tx_packet_total     <= tx_rd_r.pkts;
        out_data_r.tx_retransmit_total <= tx_rd_r.retx;
        out_data_r.rx_byte_total       <= rx_rd_r.bytes;
        out_data_r.rx_packet_total     <= rx_rd_r.pkts;
      end else begin
        out_data_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.is_read  = (req_r.req_type == REQ_READ);
  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

/* hw/rtl/per_session_traffic_counters.sv */
// ----------------------------------------------------------------------------
// per_session_traffic_counters
// Per-session rx/tx byte, packet and retransmit counters with read-back.
// ----------------------------------------------------------------------------
//  Port group  Dir  Handshake          Payload
//  in_*        in   in_valid/in_stall  psc_in_t  (rx update, tx update, read)
//  out_*       out  out_valid/out_stall psc_out_t (five counters of a session)
//
//  Each request is captured in the idle state, reading the counter memories
//  (registered read port); the execute state writes the updated record back or
//  loads the output. After reset a clearing pass writes zero to every session
//  (SESSIONS, 1024 of them), with in_stall high.
//  A read waits in the execute cycle while the output register is full and
//  stalled; updates never wait on the output side.
// ----------------------------------------------------------------------------
module per_session_traffic_counters (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  psc_pkg::psc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output psc_pkg::psc_out_t out_data
);
  import psc_pkg::*;

  psc_cmd_t    cmd;
  psc_status_t status;

  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  psc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input transfer taken while a request is in flight");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (in_stall && !out_valid))
    else $error("traffic during clearing pass");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.update && cmd.load_out) && !(cmd.clear && (cmd.update || cmd.capture)))
    else $error("conflicting datapath commands");

  a_load_follows_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !cmd.capture)
    else $error("back-to-back capture");
`endif

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for per_session_traffic_counters. A directed stimulus
// table, then random rx/tx updates and reads mostly aimed at a few busy
// sessions. A behavioral copy of the counter stores predicts every read-back,
// and results are checked in order, field by field. Both sides idle and stall
// in random bursts, and at one point the result side holds off for a long
// stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import psc_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int QUIET_AFTER  = 440;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int STUCK_LIMIT  = 6000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  psc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  psc_out_t out_data;

  per_session_traffic_counters dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // shadow copy of the per-session counters
  logic [63:0] sess_rx_bytes [SESSIONS];
  logic [31:0] sess_rx_pkts  [SESSIONS];
  logic [63:0] sess_tx_bytes [SESSIONS];
  logic [31:0] sess_tx_pkts  [SESSIONS];
  logic [31:0] sess_tx_retx  [SESSIONS];

  psc_out_t pending_reads[$];
  int       mismatches;
  int       send_idx;
  bit       quiet;
  bit       hold_go;

  // typed-in expectation travelling with the item currently offered
  bit       row_typed;
  psc_out_t row_want;

  typedef struct {
    psc_in_t  req;
    bit       typed;
    psc_out_t want;
  } stim_row_t;

  stim_row_t stim_rows[$];

  function automatic void apply_request(input psc_in_t r, output bit has_read,
                                        output psc_out_t counters);
    int s;
    s        = int'(r.session_id);
    has_read = 1'b0;
    counters = '0;
    if (r.req_type == REQ_READ) begin
      has_read = 1'b1;
      if (s < SESSIONS) begin
        counters.tx_byte_total       = sess_tx_bytes[s];
        counters.tx_packet_total     = sess_tx_pkts[s];
        counters.tx_retransmit_total = sess_tx_retx[s];
        counters.rx_byte_total       = sess_rx_bytes[s];
        counters.rx_packet_total     = sess_rx_pkts[s];
      end
    end else if (s < SESSIONS) begin
      if (r.req_type == REQ_RX) begin
        if (r.is_syn || r.is_syn_ack) begin
          sess_rx_bytes[s] = '0;
          sess_rx_pkts[s]  = '0;
        end else begin
          sess_rx_bytes[s] = sess_rx_bytes[s] + 64'(r.seg_length);
          sess_rx_pkts[s]  = sess_rx_pkts[s] + 32'd1;
        end
      end else if (r.req_type == REQ_TX) begin
        if (r.is_syn || r.is_syn_ack) begin
          sess_tx_bytes[s] = '0;
          sess_tx_pkts[s]  = '0;
          sess_tx_retx[s]  = '0;
        end else begin
          sess_tx_bytes[s] = sess_tx_bytes[s] + 64'(r.seg_length);
          sess_tx_pkts[s]  = sess_tx_pkts[s] + 32'd1;
          sess_tx_retx[s]  = sess_tx_retx[s] + 32'(r.is_retransmit);
        end
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endfunction

  task automatic add_row(input req_type_t kind, input int sid, input int len,
                         input bit syn, input bit syn_ack, input bit retx,
                         input bit typed = 1'b0, input psc_out_t want = '0);
    stim_row_t row;
    row.req.req_type      = kind;
    row.req.session_id    = 10'(sid);
    row.req.seg_length    = 16'(len);
    row.req.is_syn        = syn;
    row.req.is_syn_ack    = syn_ack;
    row.req.is_retransmit = retx;
    row.typed             = typed;
    row.want              = want;
    stim_rows.push_back(row);
  endtask

  function automatic psc_in_t random_request();
    psc_in_t r;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.req_type = REQ_RX;
    else if (pick < 80) r.req_type = REQ_TX;
    else if (pick < 97) r.req_type = REQ_READ;
    else                r.req_type = REQ_NONE;
    // most traffic lands on a few busy sessions at both ends of the id range
    if ($urandom_range(0, 3) != 0)
      r.session_id = 10'($urandom_range(0, 7)) | ($urandom_range(0, 1) ? 10'h3F8 : 10'h000);
    else
      r.session_id = 10'($urandom_range(0, 1023));
    case ($urandom_range(0, 9))
      0:       r.seg_length = 16'h0000;
      1:       r.seg_length = 16'hFFFF;
      default: r.seg_length = 16'($urandom_range(0, 65535));
    endcase
    r.is_syn        = ($urandom_range(0, 19) == 0);
    r.is_syn_ack    = ($urandom_range(0, 19) == 0);
    r.is_retransmit = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic offer(input psc_in_t r, input bit typed, input psc_out_t want);
    int seg;
    int pct;
    seg = (send_idx / 40) % 3;
    pct = quiet ? 0 : (seg == 0 ? 0 : (seg == 1 ? 12 : 35));
    send_idx++;
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_data   <= r;
    in_valid  <= 1'b1;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < SESSIONS; i++) begin
      sess_rx_bytes[i] = '0;
      sess_rx_pkts[i]  = '0;
      sess_tx_bytes[i] = '0;
      sess_tx_pkts[i]  = '0;
      sess_tx_retx[i]  = '0;
    end
  end

  // result side: random stall bursts, one long hold-off, none near the end
  initial begin
    int cyc;
    int pct;
    cyc       = 0;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      pct = ((cyc / 150) % 3 == 0) ? 0 : (((cyc / 150) % 3 == 1) ? 10 : 30);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // predict on each input transfer, check on each result transfer
  always @(posedge clk) begin : monitor
    bit       has_read;
    psc_out_t counters;
    psc_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_request(in_data, has_read, counters);
        if (has_read) pending_reads.push_back(row_typed ? row_want : counters);
      end
      if (out_valid && !out_stall) begin
        if (pending_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          want = pending_reads.pop_front();
          check_field("tx_byte_total", want.tx_byte_total, out_data.tx_byte_total);
          check_field("tx_packet_total", 64'(want.tx_packet_total),
                      64'(out_data.tx_packet_total));
          check_field("tx_retransmit_total", 64'(want.tx_retransmit_total),
                      64'(out_data.tx_retransmit_total));
          check_field("rx_byte_total", want.rx_byte_total, out_data.rx_byte_total);
          check_field("rx_packet_total", 64'(want.rx_packet_total),
                      64'(out_data.rx_packet_total));
        end
      end
    end
  end

  // watchdog: cycles without any transfer (covers the clearing pass after reset)
  always @(posedge clk) begin : watchdog
    int stuck;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
    else stuck++;
    if (stuck >= STUCK_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int       counted;
    psc_in_t  r;
    mismatches = 0;
    send_idx   = 0;
    quiet      = 1'b0;
    hold_go    = 1'b0;
    row_typed  = 1'b0;
    row_want   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed part: typed expectations where the counts are obvious
    add_row(REQ_READ, 0, 0, 0, 0, 0, 1, '0);
    add_row(REQ_READ, 1023, 65535, 1, 1, 1, 1, '0);  // unused read fields all set
    add_row(REQ_RX, 0, 65535, 0, 0, 0);
    add_row(REQ_RX, 0, 0, 0, 0, 1);                  // retransmit flag ignored on rx
    add_row(REQ_READ, 0, 0, 0, 0, 0, 1, {64'd0, 32'd0, 32'd0, 64'd65535, 32'd2});
    add_row(REQ_TX, 1023, 65535, 0, 0, 1);
    add_row(REQ_TX, 1023, 1, 0, 0, 0);
    add_row(REQ_READ, 1023, 0, 0, 0, 0, 1, {64'd65536, 32'd2, 32'd1, 64'd0, 32'd0});
    add_row(REQ_TX, 1023, 500, 1, 0, 1);             // syn zeroes, retransmit ignored
    add_row(REQ_READ, 1023, 0, 0, 0, 0, 1, '0);
    add_row(REQ_RX, 0, 7, 1, 1, 0);                  // syn and syn-ack together
    add_row(REQ_READ, 0, 0, 0, 0, 0, 1, '0);
    add_row(REQ_TX, 5, 100, 0, 0, 1);
    add_row(REQ_RX, 5, 40, 0, 0, 0);
    add_row(REQ_TX, 5, 9, 0, 1, 1);                  // syn-ack alone
    add_row(REQ_READ, 5, 0, 0, 0, 0);
    add_row(REQ_NONE, 5, 1000, 0, 0, 1);             // no result, no change
    add_row(REQ_READ, 5, 0, 0, 0, 0);
    add_row(REQ_RX, 5, 3, 0, 1, 0);
    add_row(REQ_RX, 5, 12345, 0, 0, 0);
    add_row(REQ_TX, 5, 0, 0, 0, 1);
    add_row(REQ_READ, 5, 0, 0, 0, 0);

    @(negedge clk);
    foreach (stim_rows[i]) offer(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = random_request();
      if (r.req_type != REQ_NONE) counted++;
      if (counted == HOLD_AT) hold_go = 1'b1;
      if (counted >= QUIET_AFTER) quiet = 1'b1;
      offer(r, 1'b0, '0);
    end
    in_valid <= 1'b0;

    wait (pending_reads.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
